@@ src/dest_pkg.sv @@
package dest_pkg;

    // Field widths of one input word and one result word
    localparam int IDX_W  = 6;
    localparam int EXEC_W = 20;
    localparam int MASK_W = 64;
    localparam int TIME_W = 32;

    // Largest finish time; sums above it are clamped
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // One accepted node
    typedef struct packed {
        logic [IDX_W-1:0]  node_index;
        logic [EXEC_W-1:0] exec_time;
        logic [MASK_W-1:0] pred_mask;
        logic              record_schedule;
    } item_t;

    // One result word
    typedef struct packed {
        logic [IDX_W-1:0]  node_out;
        logic [TIME_W-1:0] earliest_start;
        logic [TIME_W-1:0] finish_time;
        logic              schedule_recorded;
        logic              saturated;
    } res_t;

endpackage

@@ src/dest_ram.sv @@
module dest_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/dest_seq.sv @@
module dest_seq #(
    parameter int MAX_NODES = 64,
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // node input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dest_pkg::item_t            in_item,
    // result toward the output register
    output logic                       res_valid,
    input  logic                       res_ready,
    output dest_pkg::res_t             res,
    // finish time store
    output logic                       ram_ren,
    output logic [AW-1:0]              ram_raddr,
    input  logic [dest_pkg::TIME_W-1:0] ram_rdata,
    output logic                       ram_wen,
    output logic [AW-1:0]              ram_waddr,
    output logic [dest_pkg::TIME_W-1:0] ram_wdata
);

    import dest_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_SUM   = 2'd3;

    localparam logic [IDX_W:0] MAX_W = (IDX_W + 1)'(MAX_NODES);

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        lim_reg, lim_next;
    logic                 pend_reg, pend_next;
    logic                 pend_sel_reg, pend_sel_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [EXEC_W-1:0]    exec_reg, exec_next;
    logic [MAX_NODES-1:0] mask_reg, mask_next;
    logic                 rec_reg, rec_next;
    logic [TIME_W-1:0]    start_reg, start_next;

    logic                 accept;
    logic                 done;
    logic [IDX_W:0]       in_idx_ext;
    logic [TIME_W:0]      sum;
    logic                 sat;

    assign accept     = in_valid && in_ready;
    assign done       = res_valid && res_ready;
    assign in_idx_ext = {1'b0, in_item.node_index};

    // Handshake and store read port
    assign in_ready  = (state_reg == S_IDLE);
    assign ram_ren   = (state_reg == S_SCAN);
    assign ram_raddr = cnt_reg[AW-1:0];

    // Finish time with clamp
    assign sum = {1'b0, start_reg} + (TIME_W + 1)'(exec_reg);
    assign sat = sum[TIME_W];

    assign res_valid             = (state_reg == S_SUM);
    assign res.node_out          = idx_reg;
    assign res.earliest_start    = start_reg;
    assign res.finish_time       = sat ? TIME_MAX : sum[TIME_W-1:0];
    assign res.schedule_recorded = rec_reg;
    assign res.saturated         = sat;

    // Store the finish time as the result leaves; out-of-range nodes are not stored
    assign ram_wen   = done && ({1'b0, idx_reg} < MAX_W);
    assign ram_waddr = idx_reg[AW-1:0];
    assign ram_wdata = res.finish_time;

    // Sequencer: one store read per cycle, running max taken in the cycle after each read
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lim_next      = lim_reg;
        pend_next     = 1'b0;
        pend_sel_next = 1'b0;
        idx_next      = idx_reg;
        exec_next     = exec_reg;
        mask_next     = mask_reg;
        rec_next      = rec_reg;
        start_next    = start_reg;

        if (pend_reg && pend_sel_reg && (ram_rdata > start_reg))
        begin
            start_next = ram_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = in_item.node_index;
                    exec_next  = in_item.exec_time;
                    mask_next  = in_item.pred_mask[MAX_NODES-1:0];
                    rec_next   = in_item.record_schedule;
                    start_next = '0;
                    cnt_next   = '0;
                    if (in_idx_ext >= MAX_W)
                    begin
                        lim_next = CW'(MAX_NODES);
                    end
                    else
                    begin
                        lim_next = CW'(in_item.node_index);
                    end
                    state_next = (in_item.node_index == '0) ? S_SUM : S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next     = 1'b1;
                pend_sel_next = mask_reg[cnt_reg[AW-1:0]];
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == lim_reg - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            lim_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            lim_reg      <= lim_next;
            pend_reg     <= pend_next;
            pend_sel_reg <= pend_sel_next;
        end
    end

    // Node payload
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        exec_reg  <= exec_next;
        mask_reg  <= mask_next;
        rec_reg   <= rec_next;
        start_reg <= start_next;
    end

`ifndef SYNTHESIS
    // Reads stay below the node's own index
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_ren |-> (cnt_reg < lim_reg))
        else $error("predecessor read at or beyond node index");

    // A pending compare always follows a read
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ram_ren))
        else $error("compare without a preceding read");

    // No store write while predecessors are being read
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wen |-> (!ram_ren && !pend_reg))
        else $error("store write overlaps scan");

    // Delivering a result frees the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after result");
`endif

endmodule

@@ src/dag_earliest_start_times_unit.sv @@
// Earliest start times over a task graph. Nodes arrive in index order, each with its
// execution time and a predecessor mask; the unit returns the largest finish time among
// predecessors below the node's index (zero for none) and that start plus the execution
// time, clamped at 2^32-1 with the saturated flag set. Finish times of nodes below
// MAX_NODES are kept in a single-port-read RAM for later nodes. Each item reads its
// store entries below its index in turn, waits out the last read, then sums: the
// single RAM read port steps through one store entry per cycle. A
// finished result waits in an output register, so the next word is taken while it is
// still unread. The store is not cleared; a new graph overwrites it from node 0 up.
module dag_earliest_start_times_unit #(
    parameter int MAX_NODES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node_index[5:0], exec_time[25:6], pred_mask[89:26], zero pad [95:90]
    input  logic [95:0] s_axis_tdata,
    // record_schedule[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // node_out[5:0], earliest_start[37:6], finish_time[69:38], zero pad [71:70]
    output logic [71:0] m_axis_tdata,
    // schedule_recorded[0], saturated[1]
    output logic [1:0]  m_axis_tuser
);

    import dest_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    item_t             in_item;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              ram_ren;
    logic              ram_wen;
    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] ram_wdata;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;

    // Unpack input word
    assign in_item.node_index      = s_axis_tdata[5:0];
    assign in_item.exec_time       = s_axis_tdata[25:6];
    assign in_item.pred_mask       = s_axis_tdata[89:26];
    assign in_item.record_schedule = s_axis_tuser[0];

    dest_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_ren   (ram_ren),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_wen   (ram_wen),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    dest_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_NODES)
    ) u_store (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    // Pack result word
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_res_reg.finish_time, m_res_reg.earliest_start,
                            m_res_reg.node_out};
    assign m_axis_tuser  = {m_res_reg.saturated, m_res_reg.schedule_recorded};

endmodule

@@ tb/sv/dag_earliest_start_times_unit_tb.sv @@
`timescale 1ns / 1ps

module dag_earliest_start_times_unit_tb;

    import dest_pkg::*;

    localparam int NODE_CAP    = 64;
    localparam int RAND_TARGET = 1725;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 400;

    localparam logic [EXEC_W-1:0] EXEC_MAX = '1;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Words waiting to be sent and results waiting to be seen
    item_t       node_q[$];
    res_t        sched_exp_q[$];

    // Predictor state: finish time of every stored node
    logic [TIME_W-1:0] finish_times[NODE_CAP];

    // Generator side: which store entries have been written so far
    logic [63:0] gen_written = '0;

    item_t       drv_item;
    int          nodes_sent   = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int          tx_wait      = 0;
    int          rx_wait      = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    int          cycle_cnt    = 0;

    dag_earliest_start_times_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Bits below a node index, the only ones that can name a predecessor
    function automatic logic [63:0] below_mask(input int idx);
        if (idx >= 64)
            return '1;
        return (64'd1 << idx) - 64'd1;
    endfunction

    // Predict the result of one accepted node and update the finish store
    task automatic schedule_node(input item_t it);
        int                lim;
        logic [63:0]       preds;
        logic [TIME_W-1:0] start;
        logic [TIME_W:0]   sum;
        res_t              r;
        lim   = (int'(it.node_index) > NODE_CAP) ? NODE_CAP : int'(it.node_index);
        preds = it.pred_mask & below_mask(lim);
        start = '0;
        for (int j = 0; j < NODE_CAP; j++)
        begin
            if (preds[j] && finish_times[j] > start)
                start = finish_times[j];
        end
        sum = {1'b0, start} + {{(TIME_W+1-EXEC_W){1'b0}}, it.exec_time};
        r.node_out          = it.node_index;
        r.earliest_start    = start;
        r.schedule_recorded = it.record_schedule;
        if (sum[TIME_W])
        begin
            r.finish_time = TIME_MAX;
            r.saturated   = 1'b1;
        end
        else
        begin
            r.finish_time = sum[TIME_W-1:0];
            r.saturated   = 1'b0;
        end
        if (int'(it.node_index) < NODE_CAP)
            finish_times[it.node_index] = r.finish_time;
        sched_exp_q.insert(sched_exp_q.size(), r);
    endtask

    // Queue one node; predecessors that were never stored are dropped from the mask
    task automatic add_node(input int idx, input logic [EXEC_W-1:0] exec,
                            input logic [63:0] raw_mask, input logic rec);
        item_t it;
        it.node_index      = idx[IDX_W-1:0];
        it.exec_time       = exec;
        it.pred_mask       = raw_mask & (gen_written | ~below_mask(idx));
        it.record_schedule = rec;
        node_q.insert(node_q.size(), it);
        gen_written[idx] = 1'b1;
    endtask

    function automatic logic [EXEC_W-1:0] draw_exec(input int style);
        case (style)
            0:       return EXEC_W'($urandom_range(0, 1048575));
            1:       return EXEC_MAX;
            2:       return EXEC_W'($urandom_range(0, 15));
            default: return $urandom_range(0, 1) ? EXEC_MAX : EXEC_W'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] draw_mask(input int style, input int idx);
        logic [63:0] raw;
        logic [63:0] late;
        late = {$urandom, $urandom};
        case (style)
            0:       raw = {$urandom, $urandom};
            1:       raw = '1;
            2:       raw = (idx > 0) ? (64'd1 << $urandom_range(0, idx - 1)) : '0;
            default: raw = (idx > 0) ? (64'd1 << (idx - 1)) : '0;
        endcase
        // junk at and above the own index must be ignored
        if ($urandom_range(0, 1))
            raw = raw | (late & ~below_mask(idx));
        return raw;
    endfunction

    // A run of consecutive nodes with one mask and one time style
    task automatic gen_graph(input int first, input int len);
        int ms;
        int es;
        ms = $urandom_range(0, 3);
        es = $urandom_range(0, 3);
        for (int idx = first; idx < first + len && idx < 64; idx++)
            add_node(idx, draw_exec(es), draw_mask(ms, idx), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Driver: word by word from node_q, random gap after most accepted words
    always @(posedge clk or negedge rst_n)
    begin
        logic fire;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
            begin
                schedule_node(drv_item);
                nodes_sent <= nodes_sent + 1;
                tx_wait = ((nodes_sent / 128) % 3 == 0) ? 0 : $urandom_range(0, 7);
            end
            if (fire || !s_axis_tvalid)
            begin
                if (tx_wait == 0 && node_q.size() > 0)
                begin
                    drv_item = node_q.pop_front();
                    s_axis_tdata  <= {6'b0, drv_item.pred_mask, drv_item.exec_time,
                                      drv_item.node_index};
                    s_axis_tuser  <= drv_item.record_schedule;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (tx_wait > 0)
                        tx_wait--;
                end
            end
        end
    end

    // Long receiver hold-off once, so the output register fills and input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && nodes_sent >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.node_out          = m_axis_tdata[5:0];
                got.earliest_start    = m_axis_tdata[37:6];
                got.finish_time       = m_axis_tdata[69:38];
                got.schedule_recorded = m_axis_tuser[0];
                got.saturated         = m_axis_tuser[1];
                if (sched_exp_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual node %0d start %0d",
                             $time, got.node_out, got.earliest_start);
                    mismatches++;
                end
                else
                begin
                    want = sched_exp_q.pop_front();
                    check_field("node_out", 32'(want.node_out), 32'(got.node_out));
                    check_field("earliest_start", want.earliest_start, got.earliest_start);
                    check_field("finish_time", want.finish_time, got.finish_time);
                    check_field("schedule_recorded", 32'(want.schedule_recorded),
                                32'(got.schedule_recorded));
                    check_field("saturated", 32'(want.saturated), 32'(got.saturated));
                end
                results_seen <= results_seen + 1;
                rx_wait = ((results_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 7);
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("dag_earliest_start_times_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int len;

        // Directed: new graph, extreme times, full masks, late bits, top index
        add_node(0, '0, '1, 1'b0);
        add_node(0, EXEC_MAX, '1, 1'b1);
        for (int i = 1; i <= 18; i++)
            add_node(i, EXEC_MAX, '1, 1'(i));
        add_node(63, EXEC_MAX, '1, 1'b1);
        add_node(63, '0, '0, 1'b0);
        add_node(19, 20'd12345, ~below_mask(19), 1'b1);
        add_node(20, '0, 64'd1 << 19, 1'b0);
        add_node(0, 20'd1, '0, 1'b1);

        // Random: mostly whole graphs from node 0, some noise and partial runs
        while (node_q.size() < RAND_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 64)
                                                  : $urandom_range(1, 32);
                gen_graph(0, len);
            end
            else if (kind < 9)
            begin
                repeat ($urandom_range(1, 4))
                    add_node($urandom_range(0, 63), EXEC_W'($urandom),
                             {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end
            else
                gen_graph($urandom_range(1, 63), $urandom_range(1, 8));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (node_q.size() != 0 || s_axis_tvalid || sched_exp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sched_exp_q.size() != 0)
        begin
            $display("%0t: %0d results missing", $time, sched_exp_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("dag_earliest_start_times_unit_tb OK");
        else
            $display("dag_earliest_start_times_unit_tb NOT OK");
        $finish;
    end

endmodule
